FILE: rtl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)

`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: rtl/uer_pkg.sv
`timescale 1ns / 1ps

package uer_pkg;

	localparam int LEVEL_BITS = 10;
	localparam int CFG_W      = 16;
	localparam int CNT_W      = 17;
	localparam int TOF_W      = 32;
	localparam int IDX_W      = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = 17'h10000;

	localparam logic [LEVEL_BITS-1:0] THRESHOLD_RST  = LEVEL_BITS'(800);
	localparam logic [CFG_W-1:0]      TRIG_TICKS_RST = 16'd10;
	localparam logic [CFG_W-1:0]      START_TO_RST   = 16'd60;
	localparam logic [CFG_W-1:0]      ECHO_MAX_RST   = 16'd23;
	localparam logic [CFG_W-1:0]      REST_TICKS_RST = 16'd60;
	localparam logic [CFG_W-1:0]      TICK_US_RST    = 16'd1000;

	localparam logic [IDX_W-1:0] REG_LEVEL_THRESHOLD    = 3'd0;
	localparam logic [IDX_W-1:0] REG_TRIGGER_TICKS      = 3'd1;
	localparam logic [IDX_W-1:0] REG_ECHO_START_TIMEOUT = 3'd2;
	localparam logic [IDX_W-1:0] REG_ECHO_MAX_TICKS     = 3'd3;
	localparam logic [IDX_W-1:0] REG_REST_TICKS         = 3'd4;
	localparam logic [IDX_W-1:0] REG_TICK_US            = 3'd5;

	typedef enum logic [1:0] {
		PH_TRIG    = 2'd0,
		PH_AWAIT   = 2'd1,
		PH_MEASURE = 2'd2,
		PH_REST    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level_threshold;
		logic [CFG_W-1:0]      trigger_ticks;
		logic [CFG_W-1:0]      echo_start_timeout;
		logic [CFG_W-1:0]      echo_max_ticks;
		logic [CFG_W-1:0]      rest_ticks;
		logic [CFG_W-1:0]      tick_us;
	} cfg_t;

	typedef struct packed {
		logic             trigger_level;
		phase_t           phase;
		logic [CNT_W-1:0] echo_ticks;
		logic             no_echo;
		logic             done_res;
	} seq_res_t;

endpackage

FILE: rtl/uer_cfg.sv
`timescale 1ns / 1ps

module uer_cfg
	import uer_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold    <= THRESHOLD_RST;
			cfg_q.trigger_ticks      <= TRIG_TICKS_RST;
			cfg_q.echo_start_timeout <= START_TO_RST;
			cfg_q.echo_max_ticks     <= ECHO_MAX_RST;
			cfg_q.rest_ticks         <= REST_TICKS_RST;
			cfg_q.tick_us            <= TICK_US_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_THRESHOLD:    cfg_q.level_threshold <= cfg_data[LEVEL_BITS-1:0];
				REG_TRIGGER_TICKS:      cfg_q.trigger_ticks <= cfg_data;
				REG_ECHO_START_TIMEOUT: cfg_q.echo_start_timeout <= cfg_data;
				REG_ECHO_MAX_TICKS:     cfg_q.echo_max_ticks <= cfg_data;
				REG_REST_TICKS:         cfg_q.rest_ticks <= cfg_data;
				REG_TICK_US:            cfg_q.tick_us <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/uer_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_seq
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  valid_s1,
	input  logic [LEVEL_BITS-1:0] level_s1,
	output logic                  ready_s2,
	output logic                  valid_s2,
	output seq_res_t              res_s2,
	input  logic                  ready_s3
);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] tick_count_q, tick_count_d, cnt_inc;
	logic             trigger_q, trigger_d;
	logic [CNT_W-1:0] echo_len_q, echo_len_d;
	logic             no_echo_q, no_echo_d;
	logic             done_d;
	logic             adv;

	assign ready_s2 = !valid_s2 || ready_s3;
	assign adv      = valid_s1 && ready_s2;
	assign cnt_inc  = tick_count_q + CNT_W'(1);

	always_comb begin
		phase_d      = phase_q;
		tick_count_d = cnt_inc;
		trigger_d    = trigger_q;
		echo_len_d   = echo_len_q;
		no_echo_d    = no_echo_q;
		done_d       = 1'b0;
		case (phase_q)
			PH_TRIG: begin
				trigger_d = 1'b1;
				if (cnt_inc > {1'b0, cfg.trigger_ticks}) begin
					trigger_d    = 1'b0;
					phase_d      = PH_AWAIT;
					tick_count_d = '0;
				end
			end
			PH_AWAIT: begin
				if (level_s1 > cfg.level_threshold) begin
					phase_d      = PH_MEASURE;
					tick_count_d = '0;
				end else if (cnt_inc > {1'b0, cfg.echo_start_timeout}) begin
					phase_d      = PH_TRIG;
					tick_count_d = '0;
				end
			end
			PH_MEASURE: begin
				if (level_s1 < cfg.level_threshold) begin
					phase_d      = PH_REST;
					echo_len_d   = cnt_inc;
					no_echo_d    = 1'b0;
					tick_count_d = '0;
					done_d       = 1'b1;
				end else if (cnt_inc > {1'b0, cfg.echo_max_ticks}) begin
					phase_d      = PH_TRIG;
					echo_len_d   = '0;
					no_echo_d    = 1'b1;
					tick_count_d = '0;
					done_d       = 1'b1;
				end
			end
			PH_REST: begin
				if (cnt_inc > {1'b0, cfg.rest_ticks}) begin
					phase_d      = PH_TRIG;
					tick_count_d = '0;
				end
			end
			default: begin
				phase_d      = PH_TRIG;
				tick_count_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TRIG;
			tick_count_q <= '0;
			trigger_q    <= 1'b0;
			echo_len_q   <= '0;
			no_echo_q    <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (adv) begin
				phase_q      <= phase_d;
				tick_count_q <= tick_count_d;
				trigger_q    <= trigger_d;
				echo_len_q   <= echo_len_d;
				no_echo_q    <= no_echo_d;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.trigger_level <= trigger_d;
			res_s2.phase         <= phase_d;
			res_s2.echo_ticks    <= echo_len_d;
			res_s2.no_echo       <= no_echo_d;
			res_s2.done_res      <= done_d;
		end
	end

	`ASSERT_CLK(a_cnt_bound, clk, arst_n, tick_count_q <= CNT_MAX)
	`ASSERT_CLK(a_trig_phase, clk, arst_n, trigger_q |-> phase_q == PH_TRIG)
	`ASSERT_CLK(a_no_echo_zero, clk, arst_n, no_echo_q |-> echo_len_q == '0)
	`ASSERT_CLK(a_hold_state, clk, arst_n, !adv |=> $stable(phase_q) && $stable(tick_count_q))
	`ASSERT_CLK(a_done_phase, clk, arst_n, valid_s2 && res_s2.done_res |-> res_s2.phase == PH_REST || res_s2.phase == PH_TRIG)

endmodule

FILE: rtl/uer_tof.sv
`timescale 1ns / 1ps

module uer_tof
	import uer_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] tick_us,
	input  logic             valid_s2,
	input  seq_res_t         res_s2,
	output logic             ready_s3,
	output logic             valid_s3,
	output seq_res_t         res_s3,
	output logic [TOF_W-1:0] flight_s3,
	input  logic             out_ready
);

	logic [CNT_W+CFG_W-1:0] product;

	assign ready_s3 = !valid_s3 || out_ready;
	assign product  = CNT_W'(res_s2.echo_ticks) * (CNT_W+CFG_W)'(tick_us);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			res_s3    <= res_s2;
			flight_s3 <= product[TOF_W-1:0];
		end
	end

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps

// Ultrasonic echo ranger: trigger / await / measure / rest sequencer driven by timer ticks.
// Input channel: in_valid / in_ready with echo_level, one word per timer tick.
// Output channel: out_valid / out_ready with one result word per input word:
//   trigger_level, phase, echo_ticks, no_echo, done_res and flight_time_us.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 threshold,
//   1 trigger ticks, 2 echo start timeout, 3 echo max ticks, 4 rest ticks,
//   5 tick length in us); other indexes are ignored. Write only while idle.
// Pipeline: input register, sequencer update into a result register, then the
//   tick-length multiplier into the output register.
// Path: an accepted word moves from the input register to the result register, then to the
//   output register. Throughput: one word per cycle while out_ready is high.
// Reset: clears the sequencer to trigger phase with zero count, echo length and
//   flags, restores register defaults and empties the pipeline.
// Stall: each stage holds while the next one is full; with out_ready low the
//   three stages fill and in_ready drops, and no word is lost or repeated.

module ultrasonic_echo_ranger
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [LEVEL_BITS-1:0] echo_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  trigger_level,
	output logic [1:0]            phase,
	output logic [CNT_W-1:0]      echo_ticks,
	output logic                  no_echo,
	output logic                  done_res,
	output logic [TOF_W-1:0]      flight_time_us
);

	cfg_t                  cfg;
	logic                  valid_s1;
	logic [LEVEL_BITS-1:0] level_s1;
	logic                  ready_s2, valid_s2, ready_s3;
	seq_res_t              res_s2, res_s3;

	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= echo_level;
		end
	end

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.level_s1 (level_s1),
		.ready_s2 (ready_s2),
		.valid_s2 (valid_s2),
		.res_s2   (res_s2),
		.ready_s3 (ready_s3)
	);

	uer_tof u_tof (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_us   (cfg.tick_us),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.ready_s3  (ready_s3),
		.valid_s3  (out_valid),
		.res_s3    (res_s3),
		.flight_s3 (flight_time_us),
		.out_ready (out_ready)
	);

	assign trigger_level = res_s3.trigger_level;
	assign phase         = res_s3.phase;
	assign echo_ticks    = res_s3.echo_ticks;
	assign no_echo       = res_s3.no_echo;
	assign done_res      = res_s3.done_res;

endmodule

FILE: tb/ultrasonic_echo_ranger_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_tb;
	import uer_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam int MAX_PRINTS = 40;

	typedef struct {
		logic             trig;
		phase_t           ph;
		logic [CNT_W-1:0] ticks;
		logic             no_echo;
		logic             done;
		logic [TOF_W-1:0] tof;
	} ranging_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [LEVEL_BITS-1:0] echo_level = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  trigger_level;
	logic [1:0]            phase;
	logic [CNT_W-1:0]      echo_ticks;
	logic                  no_echo;
	logic                  done_res;
	logic [TOF_W-1:0]      flight_time_us;

	ultrasonic_echo_ranger u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.echo_level     (echo_level),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.trigger_level  (trigger_level),
		.phase          (phase),
		.echo_ticks     (echo_ticks),
		.no_echo        (no_echo),
		.done_res       (done_res),
		.flight_time_us (flight_time_us)
	);

	// ranger shadow: settings and sequencer state
	logic [LEVEL_BITS-1:0] cfg_thr;
	logic [CFG_W-1:0]      cfg_trig, cfg_start, cfg_max, cfg_rest, cfg_tick;
	phase_t                rg_phase;
	logic [CNT_W-1:0]      rg_count, rg_echo;
	logic                  rg_trig, rg_no_echo;

	logic [LEVEL_BITS-1:0] level_q[$];
	ranging_t              flight_q[$];

	int ticks_in, rx_words, errors, captures, timeouts, settings;
	int burst_left, gap_left;
	int rx_mode, rx_mode_left, hold_left;
	logic [7:0] rx_pattern;
	logic next_ready;
	ranging_t want;
	logic [LEVEL_BITS-1:0] opening [25];
	int random_base;

	initial forever #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (errors < MAX_PRINTS)
			$display("mismatch on %s at word %0d: got %0h, want %0h", what, rx_words, got,
				exp_val);
		errors++;
	endtask

	function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		case (idx)
		REG_LEVEL_THRESHOLD:    cfg_thr = val[LEVEL_BITS-1:0];
		REG_TRIGGER_TICKS:      cfg_trig = val;
		REG_ECHO_START_TIMEOUT: cfg_start = val;
		REG_ECHO_MAX_TICKS:     cfg_max = val;
		REG_REST_TICKS:         cfg_rest = val;
		REG_TICK_US:            cfg_tick = val;
		default: ;
		endcase
	endfunction

	function automatic void advance_ranger(input logic [LEVEL_BITS-1:0] lvl);
		ranging_t r;
		r.done = 1'b0;
		rg_count = rg_count + 1'b1;
		case (rg_phase)
		PH_TRIG: begin
			rg_trig = 1'b1;
			if (rg_count > cfg_trig) begin
				rg_trig = 1'b0;
				rg_phase = PH_AWAIT;
				rg_count = '0;
			end
		end
		PH_AWAIT: begin
			if (lvl > cfg_thr) begin
				rg_phase = PH_MEASURE;
				rg_count = '0;
			end
			if (rg_count > cfg_start) begin
				rg_phase = PH_TRIG;
				rg_count = '0;
			end
		end
		PH_MEASURE: begin
			if (lvl < cfg_thr) begin
				rg_phase = PH_REST;
				rg_echo = rg_count;
				rg_no_echo = 1'b0;
				rg_count = '0;
				r.done = 1'b1;
				captures++;
			end
			if (rg_count > cfg_max) begin
				rg_phase = PH_TRIG;
				rg_count = '0;
				rg_echo = '0;
				rg_no_echo = 1'b1;
				r.done = 1'b1;
				timeouts++;
			end
		end
		default: begin
			if (rg_count > cfg_rest) begin
				rg_phase = PH_TRIG;
				rg_count = '0;
			end
		end
		endcase
		r.trig = rg_trig;
		r.ph = rg_phase;
		r.ticks = rg_echo;
		r.no_echo = rg_no_echo;
		r.tof = TOF_W'(rg_echo) * TOF_W'(cfg_tick);
		flight_q.push_back(r);
	endfunction

	function automatic logic [LEVEL_BITS-1:0] echo_high();
		if (cfg_thr == '1)
			return '1;
		if ($urandom_range(0, 3) == 0)
			return cfg_thr + 1'b1;
		return LEVEL_BITS'($urandom_range(int'(cfg_thr) + 1, (1 << LEVEL_BITS) - 1));
	endfunction

	function automatic logic [LEVEL_BITS-1:0] echo_low();
		if (cfg_thr == '0)
			return '0;
		if ($urandom_range(0, 3) == 0)
			return cfg_thr - 1'b1;
		return LEVEL_BITS'($urandom_range(0, int'(cfg_thr) - 1));
	endfunction

	function automatic logic [CFG_W-1:0] pick_span(input bit allow_long);
		if (allow_long && $urandom_range(0, 11) == 0)
			return '1;
		if ($urandom_range(0, 7) == 0)
			return '0;
		return CFG_W'($urandom_range(1, 12));
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// echo pulses with random lengths, mixed with raw noise
	task automatic queue_pulses(input int n, input int max_run);
		int added, lo_run, hi_run;
		added = 0;
		while (added < n) begin
			if ($urandom_range(0, 6) == 0) begin
				level_q.push_back(LEVEL_BITS'($urandom));
				added++;
			end else begin
				lo_run = $urandom_range(0, max_run);
				hi_run = $urandom_range(1, max_run);
				repeat (lo_run) level_q.push_back(echo_low());
				repeat (hi_run)
					level_q.push_back(($urandom_range(0, 9) == 0) ? cfg_thr : echo_high());
				added += lo_run + hi_run;
			end
		end
	endtask

	task automatic shuffle_regs();
		logic [CFG_W-1:0] word;
		word = CFG_W'($urandom);
		case ($urandom_range(0, 5))
		0: word[LEVEL_BITS-1:0] = '0;
		1: word[LEVEL_BITS-1:0] = '1;
		default: ;
		endcase
		if ($urandom_range(0, 3) != 0) write_reg(REG_LEVEL_THRESHOLD, word);
		if ($urandom_range(0, 3) != 0) write_reg(REG_TRIGGER_TICKS, pick_span(1'b0));
		if ($urandom_range(0, 3) != 0) write_reg(REG_ECHO_START_TIMEOUT, pick_span(1'b1));
		if ($urandom_range(0, 3) != 0) write_reg(REG_ECHO_MAX_TICKS, pick_span(1'b1));
		if ($urandom_range(0, 3) != 0) write_reg(REG_REST_TICKS, pick_span(1'b1));
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 5))
			0: write_reg(REG_TICK_US, '0);
			1: write_reg(REG_TICK_US, '1);
			default: write_reg(REG_TICK_US, CFG_W'($urandom));
			endcase
		end
		if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_A, CFG_W'($urandom));
		settings++;
	endtask

	// wait until the queued levels are sent and the pipeline has drained
	task automatic settle();
		do @(negedge clk); while (level_q.size() != 0 || in_valid || flight_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			echo_level <= '0;
			burst_left = 0;
			gap_left = 0;
			cfg_thr = THRESHOLD_RST;
			cfg_trig = TRIG_TICKS_RST;
			cfg_start = START_TO_RST;
			cfg_max = ECHO_MAX_RST;
			cfg_rest = REST_TICKS_RST;
			cfg_tick = TICK_US_RST;
			rg_phase = PH_TRIG;
			rg_count = '0;
			rg_trig = 1'b0;
			rg_echo = '0;
			rg_no_echo = 1'b0;
		end else begin
			if (cfg_we)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				advance_ranger(echo_level);
				ticks_in++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (level_q.size() != 0) begin
					in_valid <= 1'b1;
					echo_level <= level_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode = 0;
			rx_mode_left = 0;
			hold_left = 0;
			rx_pattern = '0;
		end else begin
			if (out_valid && out_ready) begin
				rx_words++;
				if (flight_q.size() == 0) begin
					report_mismatch("unexpected word", flight_time_us, '0);
				end else begin
					want = flight_q.pop_front();
					if (trigger_level !== want.trig)
						report_mismatch("trigger_level", trigger_level, want.trig);
					if (phase !== want.ph)
						report_mismatch("phase", phase, want.ph);
					if (echo_ticks !== want.ticks)
						report_mismatch("echo_ticks", echo_ticks, want.ticks);
					if (no_echo !== want.no_echo)
						report_mismatch("no_echo", no_echo, want.no_echo);
					if (done_res !== want.done)
						report_mismatch("done_res", done_res, want.done);
					if (flight_time_us !== want.tof)
						report_mismatch("flight_time_us", flight_time_us, want.tof);
				end
				if (rx_words % 500 == 250)
					hold_left = 160;
			end
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(8, 80);
				rx_pattern = 8'($urandom);
			end else begin
				rx_mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				case (rx_mode)
				0: next_ready = 1'b1;
				1: next_ready = 1'($urandom_range(0, 1));
				2: next_ready = ($urandom_range(0, 3) == 0);
				default: begin
					next_ready = rx_pattern[0];
					rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
				end
				endcase
			end
			out_ready <= next_ready;
		end
	end

	initial begin
		#5000000;
		$display("ultrasonic_echo_ranger_tb: errors");
		$finish;
	end

	initial begin
		opening = '{10'd0, 10'd1023, 10'd512, 10'd800, 10'd801, 10'd799, 10'd0, 10'd0,
			10'd0, 10'd0, 10'd0, 10'd800, 10'd801, 10'd800, 10'd1023, 10'd1000, 10'd799,
			10'd0, 10'd1023, 10'd800, 10'd801, 10'd0, 10'd1, 10'd1022, 10'd799};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settings = 1;
		foreach (opening[i]) level_q.push_back(opening[i]);
		settle();

		// short timings, zero tick length, spare indexes ignored
		write_reg(REG_LEVEL_THRESHOLD, 16'd512);
		write_reg(REG_TRIGGER_TICKS, 16'd1);
		write_reg(REG_ECHO_START_TIMEOUT, 16'd5);
		write_reg(REG_ECHO_MAX_TICKS, 16'd4);
		write_reg(REG_REST_TICKS, 16'd2);
		write_reg(REG_TICK_US, 16'd0);
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'h1234);
		settings++;
		queue_pulses(150, 6);
		settle();

		write_reg(REG_LEVEL_THRESHOLD, 16'd0);
		write_reg(REG_TRIGGER_TICKS, 16'd0);
		write_reg(REG_ECHO_START_TIMEOUT, 16'd0);
		write_reg(REG_ECHO_MAX_TICKS, 16'd0);
		write_reg(REG_REST_TICKS, 16'd0);
		write_reg(REG_TICK_US, 16'hFFFF);
		settings++;
		queue_pulses(100, 4);
		settle();

		// upper bits of the threshold word drop off
		write_reg(REG_LEVEL_THRESHOLD, 16'hFFFF);
		write_reg(REG_TRIGGER_TICKS, 16'd3);
		write_reg(REG_ECHO_START_TIMEOUT, 16'd10);
		write_reg(REG_ECHO_MAX_TICKS, 16'd12);
		write_reg(REG_REST_TICKS, 16'd5);
		write_reg(REG_TICK_US, 16'd1);
		settings++;
		queue_pulses(60, 6);
		settle();

		write_reg(REG_LEVEL_THRESHOLD, 16'hFDF4);
		write_reg(REG_TRIGGER_TICKS, 16'd0);
		write_reg(REG_ECHO_START_TIMEOUT, 16'hFFFF);
		write_reg(REG_ECHO_MAX_TICKS, 16'hFFFF);
		write_reg(REG_REST_TICKS, 16'hFFFF);
		write_reg(REG_TICK_US, 16'hFFFF);
		settings++;
		queue_pulses(300, 120);
		settle();

		random_base = ticks_in;
		while (ticks_in - random_base < 450) begin
			shuffle_regs();
			queue_pulses($urandom_range(80, 200), $urandom_range(2, 16));
			settle();
		end

		repeat (8) @(negedge clk);
		$display("ultrasonic_echo_ranger_tb: %0d ticks over %0d register settings",
			ticks_in, settings);
		$display("ultrasonic_echo_ranger_tb: %0d echoes captured, %0d no-echo timeouts, %0d %s",
			captures, timeouts, errors, "mismatches");
		if (errors == 0)
			$display("ultrasonic_echo_ranger_tb: clean");
		else
			$display("ultrasonic_echo_ranger_tb: errors");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/uer_pkg.sv
rtl/uer_cfg.sv
rtl/uer_seq.sv
rtl/uer_tof.sv
rtl/ultrasonic_echo_ranger.sv
tb/ultrasonic_echo_ranger_tb.sv
